// ===== rtl/core/cell_height_kalman_fusion_unit_assert.svh =====
// assertion macros for the cell height fusion unit
// no dependencies; included by the rtl files that carry checks
`ifndef CELL_HEIGHT_KALMAN_FUSION_UNIT_ASSERT_SVH
`define CELL_HEIGHT_KALMAN_FUSION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHKF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chkf assertion failed");
`define CHKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chkf assertion failed");
`else
`define CHKF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CHKF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/chkf_pkg.sv =====
// types, constants and helper functions of the cell height fusion unit
// no dependencies
`default_nettype none

package chkf_pkg;

   localparam int IDX_W       = 12;
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int RECIP_SHIFT = 24;
   localparam int CNT_W       = 6;
   localparam int BLEND_SHIFT = 33;

   localparam logic [16:0]      GAIN_MIN         = 17'd13107;
   localparam logic [16:0]      GAIN_MAX         = 17'd52429;
   localparam logic [16:0]      GAIN_ONE         = 17'd65536;
   localparam logic [CNT_W-1:0] DIV_STEPS_GAIN   = 6'd16;

   // floor((4a + 2) / 5) == (a * BLEND_RECIP + BLEND_BIAS) >> BLEND_SHIFT for any a below 2^32
   localparam logic [32:0]      BLEND_RECIP      = 33'd6871947674;
   localparam logic [31:0]      BLEND_BIAS       = 32'd3435973836;

   localparam logic [31:0] MIN_VARIANCE_RST  = 32'd7;
   localparam logic [31:0] MAX_VARIANCE_RST  = 32'd65536;
   localparam logic [31:0] THRESHOLD_SQ_RST  = 32'd589824;
   localparam logic [31:0] RESET_DELTA_RST   = 32'd6554;
   localparam logic [31:0] VARIANCE_BUMP_RST = 32'd655;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST  = 2'd0,
      KIND_BLEND  = 2'd1,
      KIND_KALMAN = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VARIANCE  = 3'd0,
      CSR_MAX_VARIANCE  = 3'd1,
      CSR_THRESHOLD_SQ  = 3'd2,
      CSR_RESET_DELTA   = 3'd3,
      CSR_VARIANCE_BUMP = 3'd4
   } csr_index_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_ADDR   = 10'b0000000010,
      S_LOAD   = 10'b0000000100,
      S_SQ     = 10'b0000001000,
      S_GATE   = 10'b0000010000,
      S_BLEND  = 10'b0000100000,
      S_DIV    = 10'b0001000000,
      S_KH     = 10'b0010000000,
      S_KV     = 10'b0100000000,
      S_FINISH = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [31:0]        variance;
      logic signed [31:0] height;
   } cell_type;

   // upper bound wins when the bounds cross
   function automatic logic [31:0] clamp_variance(input logic [32:0] value,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi);
      logic [32:0] r;
      r = (value < {1'b0, lo}) ? {1'b0, lo} : value;
      if (r > {1'b0, hi}) begin
         r = {1'b0, hi};
      end
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] saturate_height(input logic signed [34:0] value);
      logic signed [31:0] r;
      if (value > 35'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (value < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = value[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cell_height_kalman_fusion_unit.sv =====
// Cell height fusion unit: per-cell scalar Kalman update of a height grid.
//
// Input channel req_* (valid/ready) carries a cell index, a Q16.16 height
// and its variance; result channel rsp_* (valid/ready) returns the new height,
// new variance and the kind of update. One result per transaction, in order.
// Configuration registers are written via csr_we/csr_index/csr_wdata; the user
// must write them only while the unit is idle; the unit does not enforce it.
// Indexes past the register list are ignored. Items are processed one at a time:
// address and load, then finish for an empty cell, else square and gate, then
// finish for an upward blend, a blend state for a downward one, or the divider,
// KH and KV for a Kalman update. The Kalman gain comes from a restoring divider
// (one quotient bit per cycle, 16 steps), and the downward blend scales by 0.8
// through one reciprocal product. Cell state sits in one single-port-write
// memory with a registered read. After reset a clearing pass empties every cell;
// req_ready stays low meanwhile. A result waits in the output register while
// rsp_ready is low; the unit accepts the next item meanwhile and only holds
// before writing its result back if the output register is still full.
// depends on chkf_pkg and cell_height_kalman_fusion_unit_assert.svh
`default_nettype none
`include "cell_height_kalman_fusion_unit_assert.svh"

module cell_height_kalman_fusion_unit
   import chkf_pkg::*;
#(
   parameter int unsigned GRID_CELLS = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [IDX_W-1:0]         req_cell_index,
   input  wire logic signed [DATA_W-1:0] req_measured_height,
   input  wire logic [DATA_W-1:0]        req_measured_variance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_new_height,
   output logic [DATA_W-1:0]             rsp_new_variance,
   output logic [KIND_W-1:0]             rsp_update_kind,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata
);

   localparam int unsigned ADDR_W  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
   localparam int unsigned RP_W    = IDX_W + RECIP_W;
   localparam int unsigned QN_W    = IDX_W + 17;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(GRID_CELLS) - 64'd1) / 64'(GRID_CELLS));
   localparam logic [16:0]       GRID_N    = 17'(GRID_CELLS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(GRID_CELLS - 1);

   // control state
   state_type   state_ff, state_in;
   logic        clear_active_ff, clear_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] min_var_ff, min_var_in;
   logic [31:0] max_var_ff, max_var_in;
   logic [31:0] thresh_ff, thresh_in;
   logic [31:0] reset_delta_ff, reset_delta_in;
   logic [31:0] bump_ff, bump_in;

   // payload state
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    quot_idx_ff, quot_idx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic signed [31:0]  meas_h_ff, meas_h_in;
   logic [31:0]         meas_var_ff, meas_var_in;
   logic signed [31:0]  height_ff, height_in;
   logic [31:0]         var_ff, var_in;
   logic signed [32:0]  delta_ff, delta_in;
   logic [32:0]         comb_ff, comb_in;
   logic [63:0]         sq_ff, sq_in;
   logic signed [33:0]  off_ff, off_in;
   logic [32:0]         vpre_ff, vpre_in;
   kind_type            kind_ff, kind_in;
   logic [32:0]         rem_ff, rem_in;
   logic [32:0]         div_ff, div_in;
   logic [16:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [16:0]         gain_ff, gain_in;
   logic signed [31:0]  rsp_height_ff, rsp_height_in;
   logic [31:0]         rsp_var_ff, rsp_var_in;
   kind_type            rsp_kind_ff, rsp_kind_in;

   // cell memory
   cell_type            cell_mem [0:GRID_CELLS-1];
   cell_type            rd_cell_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   cell_type            mem_wdata;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_raddr;

   // datapath helpers
   logic [RP_W-1:0]     recip_prod;
   logic [QN_W-1:0]     qn_prod;
   logic [IDX_W-1:0]    idx_mod;
   logic [31:0]         abs_d;
   logic signed [33:0]  mul_a, mul_b;
   logic signed [67:0]  mul_p;
   logic [32:0]         comb_sum;
   logic                gate_hit, jump_hit, div_top, div_ge, finish_go;
   logic [33:0]         rem_sh, half_sum;
   logic [66:0]         blend_sum;
   logic [16:0]         gain_raw, one_minus_g;
   logic signed [67:0]  kh_round;
   logic [48:0]         kv_round;
   logic signed [34:0]  height_sum;

   assign req_ready        = (state_ff == S_IDLE) && !clear_active_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_height   = rsp_height_ff;
   assign rsp_new_variance = rsp_var_ff;
   assign rsp_update_kind  = rsp_kind_ff;

   // index reduction modulo the grid size: reciprocal product, then one subtract
   assign recip_prod = RP_W'(req_cell_index) * RP_W'(RECIP);
   assign qn_prod    = QN_W'(quot_idx_ff) * QN_W'(GRID_N);
   assign idx_mod    = idx_ff - qn_prod[IDX_W-1:0];

   assign abs_d = delta_ff[32] ? 32'(-delta_ff) : delta_ff[31:0];

   // shared signed multiplier
   assign one_minus_g = GAIN_ONE - gain_ff;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = {2'b00, abs_d};
            mul_b = {2'b00, abs_d};
         end
         S_GATE: begin
            mul_a = {2'b00, thresh_ff};
            mul_b = {1'b0, comb_ff};
         end
         S_BLEND: begin
            mul_a = {2'b00, abs_d};
            mul_b = {1'b0, BLEND_RECIP};
         end
         S_KH: begin
            mul_a = {17'd0, gain_ff};
            mul_b = {delta_ff[32], delta_ff};
         end
         S_KV: begin
            mul_a = {17'd0, one_minus_g};
            mul_b = {2'b00, var_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign comb_sum   = {1'b0, rd_cell_ff.variance} + {1'b0, meas_var_ff};
   assign gate_hit   = {1'b0, sq_ff} > mul_p[64:0];
   assign jump_hit   = abs_d > reset_delta_ff;
   assign div_top    = {1'b0, var_ff} >= comb_ff;
   assign half_sum   = {delta_ff[32], delta_ff} + 34'd1;
   assign blend_sum  = mul_p[66:0] + {35'd0, BLEND_BIAS};
   assign rem_sh     = {rem_ff, 1'b0};
   assign div_ge     = rem_sh >= {1'b0, div_ff};
   assign kh_round   = mul_p + 68'sd32768;
   assign kv_round   = mul_p[48:0] + 49'd32768;
   assign height_sum = {{3{height_ff[31]}}, height_ff} + {off_ff[33], off_ff};
   assign finish_go  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      clear_active_in = clear_active_ff;
      clr_addr_in     = clr_addr_ff;
      rsp_valid_in    = rsp_valid_ff;
      min_var_in      = min_var_ff;
      max_var_in      = max_var_ff;
      thresh_in       = thresh_ff;
      reset_delta_in  = reset_delta_ff;
      bump_in         = bump_ff;
      idx_in          = idx_ff;
      quot_idx_in     = quot_idx_ff;
      addr_in         = addr_ff;
      meas_h_in       = meas_h_ff;
      meas_var_in     = meas_var_ff;
      height_in       = height_ff;
      var_in          = var_ff;
      delta_in        = delta_ff;
      comb_in         = comb_ff;
      sq_in           = sq_ff;
      off_in          = off_ff;
      vpre_in         = vpre_ff;
      kind_in         = kind_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      gain_in         = gain_ff;
      gain_raw        = '0;
      rsp_height_in   = rsp_height_ff;
      rsp_var_in      = rsp_var_ff;
      rsp_kind_in     = rsp_kind_ff;
      mem_re          = 1'b0;
      mem_raddr       = ADDR_W'(idx_mod);
      mem_we          = 1'b0;
      mem_waddr       = addr_ff;
      mem_wdata       = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_MIN_VARIANCE:  min_var_in     = csr_wdata;
            CSR_MAX_VARIANCE:  max_var_in     = csr_wdata;
            CSR_THRESHOLD_SQ:  thresh_in      = csr_wdata;
            CSR_RESET_DELTA:   reset_delta_in = csr_wdata;
            CSR_VARIANCE_BUMP: bump_in        = csr_wdata;
            default: ;
         endcase
      end

      if (clear_active_ff) begin
         mem_we      = 1'b1;
         mem_waddr   = clr_addr_ff;
         mem_wdata   = '0;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_CELL) begin
            clear_active_in = 1'b0;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               idx_in      = req_cell_index;
               quot_idx_in = recip_prod[RECIP_SHIFT +: IDX_W];
               meas_h_in   = req_measured_height;
               meas_var_in = req_measured_variance;
               state_in    = S_ADDR;
            end
         end
         S_ADDR: begin
            mem_re   = 1'b1;
            addr_in  = ADDR_W'(idx_mod);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!rd_cell_ff.valid) begin
               height_in = meas_h_ff;
               off_in    = '0;
               vpre_in   = {1'b0, meas_var_ff};
               kind_in   = KIND_FIRST;
               state_in  = S_FINISH;
            end else begin
               height_in = rd_cell_ff.height;
               var_in    = rd_cell_ff.variance;
               delta_in  = {meas_h_ff[31], meas_h_ff}
                         - {rd_cell_ff.height[31], rd_cell_ff.height};
               comb_in   = (comb_sum == '0) ? 33'd1 : comb_sum;
               state_in  = S_SQ;
            end
         end
         S_SQ: begin
            sq_in    = mul_p[63:0];
            state_in = S_GATE;
         end
         S_GATE: begin
            if (gate_hit && jump_hit) begin
               kind_in = KIND_BLEND;
               vpre_in = {1'b0, var_ff} + {1'b0, bump_ff};
               if (delta_ff[32]) begin
                  state_in = S_BLEND;
               end else begin
                  off_in   = {half_sum[33], half_sum[33:1]};
                  state_in = S_FINISH;
               end
            end else begin
               kind_in  = KIND_KALMAN;
               div_in   = comb_ff;
               rem_in   = div_top ? 33'({1'b0, var_ff} - comb_ff) : {1'b0, var_ff};
               quo_in   = {16'd0, div_top};
               cnt_in   = DIV_STEPS_GAIN;
               state_in = S_DIV;
            end
         end
         S_BLEND: begin
            // lower measurement: offset is -floor((4|d| + 2) / 5)
            off_in   = 34'd0 - blend_sum[BLEND_SHIFT +: 34];
            state_in = S_FINISH;
         end
         S_DIV: begin
            rem_in = div_ge ? 33'(rem_sh - {1'b0, div_ff}) : rem_sh[32:0];
            quo_in = {quo_ff[15:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               gain_raw = {quo_ff[15:0], div_ge};
               if (gain_raw < GAIN_MIN) begin
                  gain_in = GAIN_MIN;
               end else if (gain_raw > GAIN_MAX) begin
                  gain_in = GAIN_MAX;
               end else begin
                  gain_in = gain_raw;
               end
               state_in = S_KH;
            end
         end
         S_KH: begin
            off_in   = kh_round[49:16];
            state_in = S_KV;
         end
         S_KV: begin
            vpre_in  = kv_round[48:16];
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_go) begin
               rsp_height_in = saturate_height(height_sum);
               rsp_var_in    = clamp_variance(vpre_ff, min_var_ff, max_var_ff);
               rsp_kind_in   = kind_ff;
               rsp_valid_in  = 1'b1;
               mem_we        = 1'b1;
               mem_waddr     = addr_ff;
               mem_wdata     = '{valid: 1'b1, variance: rsp_var_in,
                                 height: rsp_height_in};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         clear_active_ff <= 1'b1;
         clr_addr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         min_var_ff      <= MIN_VARIANCE_RST;
         max_var_ff      <= MAX_VARIANCE_RST;
         thresh_ff       <= THRESHOLD_SQ_RST;
         reset_delta_ff  <= RESET_DELTA_RST;
         bump_ff         <= VARIANCE_BUMP_RST;
      end else begin
         state_ff        <= state_in;
         clear_active_ff <= clear_active_in;
         clr_addr_ff     <= clr_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
         min_var_ff      <= min_var_in;
         max_var_ff      <= max_var_in;
         thresh_ff       <= thresh_in;
         reset_delta_ff  <= reset_delta_in;
         bump_ff         <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      quot_idx_ff   <= quot_idx_in;
      addr_ff       <= addr_in;
      meas_h_ff     <= meas_h_in;
      meas_var_ff   <= meas_var_in;
      height_ff     <= height_in;
      var_ff        <= var_in;
      delta_ff      <= delta_in;
      comb_ff       <= comb_in;
      sq_ff         <= sq_in;
      off_ff        <= off_in;
      vpre_ff       <= vpre_in;
      kind_ff       <= kind_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      gain_ff       <= gain_in;
      rsp_height_ff <= rsp_height_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   // cell memory, registered read; a write always lands before the next read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_cell_ff <= cell_mem[mem_raddr];
      end
   end

   `CHKF_ASSERT_NEXT(a_accept_starts_lookup, clock, reset, req_valid && req_ready, state_ff == S_ADDR)
   `CHKF_ASSERT_IMPLY(a_gain_in_range, clock, reset, state_ff == S_KH, (gain_ff >= GAIN_MIN) && (gain_ff <= GAIN_MAX))
   `CHKF_ASSERT_IMPLY(a_div_rem_below_divisor, clock, reset, state_ff == S_DIV, rem_ff < div_ff)
   `CHKF_ASSERT_IMPLY(a_write_source, clock, reset, mem_we, clear_active_ff || (state_ff == S_FINISH))
   `CHKF_ASSERT_NEXT(a_finish_holds_when_full, clock, reset, (state_ff == S_FINISH) && rsp_valid_ff && !rsp_ready, state_ff == S_FINISH)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench for cell_height_kalman_fusion_unit: random and directed height measurements,
// predicted per cell in a scoreboard class and checked field by field on the result channel
// depends on chkf_pkg and the unit's rtl

module tb;
   import chkf_pkg::*;

   localparam int GRID_CELLS      = 4096;
   localparam int HOT_CELLS       = 24;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int NEAR_SPAN       = 8192;
   localparam int DRAIN_CYCLES    = 48;
   localparam int REPORT_LINES    = 100;
   localparam int CYCLE_LIMIT     = 500000;

   localparam logic signed [DATA_W-1:0] HEIGHT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] HEIGHT_MIN = 32'sh80000000;
   localparam logic [DATA_W-1:0]        ALL_ONES   = 32'hFFFFFFFF;

   typedef struct {
      logic signed [DATA_W-1:0] height;
      logic [DATA_W-1:0]        variance;
      kind_type                 kind;
   } fusion_estimate_type;

   class fusion_scoreboard_type;
      logic signed [DATA_W-1:0] cell_height [GRID_CELLS];
      logic [DATA_W-1:0]        cell_variance [GRID_CELLS];
      bit                       cell_filled [GRID_CELLS];
      logic [DATA_W-1:0]        min_variance  = MIN_VARIANCE_RST;
      logic [DATA_W-1:0]        max_variance  = MAX_VARIANCE_RST;
      logic [DATA_W-1:0]        threshold_sq  = THRESHOLD_SQ_RST;
      logic [DATA_W-1:0]        reset_delta   = RESET_DELTA_RST;
      logic [DATA_W-1:0]        variance_bump = VARIANCE_BUMP_RST;
      fusion_estimate_type      estimates [$];
      int                       errors;

      task report(string what);
         if (errors < REPORT_LINES) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
         errors++;
      endtask

      function int pending();
         return estimates.size();
      endfunction

      function longint height_of(logic [IDX_W-1:0] idx);
         return cell_filled[idx] ? longint'(cell_height[idx]) : 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [DATA_W-1:0] value);
         case (index)
            CSR_MIN_VARIANCE:  min_variance  = value;
            CSR_MAX_VARIANCE:  max_variance  = value;
            CSR_THRESHOLD_SQ:  threshold_sq  = value;
            CSR_RESET_DELTA:   reset_delta   = value;
            CSR_VARIANCE_BUMP: variance_bump = value;
            default: ;
         endcase
      endfunction

      // upper bound wins when the bounds cross
      function logic [DATA_W-1:0] bound_variance(longint unsigned x);
         if (x < min_variance) x = min_variance;
         if (x > max_variance) x = max_variance;
         return DATA_W'(x);
      endfunction

      function logic signed [DATA_W-1:0] limit_height(longint x);
         if (x > longint'(HEIGHT_MAX)) return HEIGHT_MAX;
         if (x < longint'(HEIGHT_MIN)) return HEIGHT_MIN;
         return DATA_W'(x);
      endfunction

      function longint div_floor(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q--;
         return q;
      endfunction

      function void note_measurement(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] m,
                                     logic [DATA_W-1:0] mv);
         fusion_estimate_type e;
         longint           h, d, off;
         longint unsigned  v, g;
         logic [32:0]      ad, c;
         logic [127:0]     dsq, gate;
         if (!cell_filled[idx]) begin
            e.height   = m;
            e.variance = bound_variance(mv);
            e.kind     = KIND_FIRST;
         end else begin
            h   = cell_height[idx];
            v   = cell_variance[idx];
            d   = longint'(m) - h;
            ad  = (d < 0) ? 33'(-d) : 33'(d);
            c   = {1'b0, cell_variance[idx]} + {1'b0, mv};
            if (c == 0) c = 1;
            dsq  = ad * ad;
            gate = threshold_sq * c;
            if (dsq > gate && ad > reset_delta) begin
               // downward jumps follow the measurement harder than upward ones
               if (d < 0) off = div_floor(8 * d + 5, 10);
               else off = (d + 1) >>> 1;
               e.height   = limit_height(h + off);
               e.variance = bound_variance(v + variance_bump);
               e.kind     = KIND_BLEND;
            end else begin
               g = (v << 16) / c;
               if (g < GAIN_MIN) g = GAIN_MIN;
               if (g > GAIN_MAX) g = GAIN_MAX;
               off = (longint'(g) * d + 32768) >>> 16;
               e.height   = limit_height(h + off);
               e.variance = bound_variance(((65536 - g) * v + 32768) >> 16);
               e.kind     = KIND_KALMAN;
            end
         end
         cell_height[idx]   = e.height;
         cell_variance[idx] = e.variance;
         cell_filled[idx]   = 1'b1;
         estimates.insert(estimates.size(), e);
      endfunction

      task check_estimate(logic signed [DATA_W-1:0] height, logic [DATA_W-1:0] variance,
                          logic [KIND_W-1:0] kind);
         fusion_estimate_type want;
         if (estimates.size() == 0) begin
            report($sformatf("result with nothing outstanding, height %0d", height));
         end else begin
            want = estimates.pop_front();
            if (height !== want.height) begin
               report($sformatf("height %0d, expected %0d", height, want.height));
            end
            if (variance !== want.variance) begin
               report($sformatf("variance %0d, expected %0d", variance, want.variance));
            end
            if (kind !== want.kind) begin
               report($sformatf("update kind %0d, expected %s", kind, want.kind.name()));
            end
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [IDX_W-1:0]         req_cell_index = '0;
   logic signed [DATA_W-1:0] req_measured_height = '0;
   logic [DATA_W-1:0]        req_measured_variance = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_new_height;
   logic [DATA_W-1:0]        rsp_new_variance;
   logic [KIND_W-1:0]        rsp_update_kind;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   bit                       no_idle = 1'b0;
   int                       cycle_count = 0;
   logic [IDX_W-1:0]         hot_cells [HOT_CELLS];
   fusion_scoreboard_type    fusion = new();

   cell_height_kalman_fusion_unit #(.GRID_CELLS(GRID_CELLS)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cell_index        (req_cell_index),
      .req_measured_height   (req_measured_height),
      .req_measured_variance (req_measured_variance),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_new_height        (rsp_new_height),
      .rsp_new_variance      (rsp_new_variance),
      .rsp_update_kind       (rsp_update_kind),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL cell_height_kalman_fusion_unit");
         $finish;
      end
   end

   // every transaction is noted or checked at the edge that moves it
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) fusion.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            fusion.note_measurement(req_cell_index, req_measured_height,
                                    req_measured_variance);
         end
         if (rsp_valid && rsp_ready) begin
            fusion.check_estimate(rsp_new_height, rsp_new_variance, rsp_update_kind);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 13);
   end

   task automatic send_measurement(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] m,
                                   logic [DATA_W-1:0] mv);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_cell_index        <= idx;
      req_measured_height   <= m;
      req_measured_variance <= mv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_measurement();
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] m;
      logic [DATA_W-1:0]        mv;
      longint                   base;
      int unsigned              pick;
      if ($urandom_range(99) < 75) idx = hot_cells[$urandom_range(HOT_CELLS - 1)];
      else idx = IDX_W'($urandom);
      base = fusion.height_of(idx);
      pick = $urandom_range(99);
      if (pick < 40) begin
         m = DATA_W'(base + longint'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN);
      end else if (pick < 55) begin
         m = DATA_W'(base + longint'($urandom_range(1 << 24, 1 << 16)));
      end else if (pick < 70) begin
         m = DATA_W'(base - longint'($urandom_range(1 << 24, 1 << 16)));
      end else if (pick < 88) begin
         m = $urandom;
      end else begin
         case ($urandom_range(3))
            0: m = HEIGHT_MAX;
            1: m = HEIGHT_MIN;
            2: m = '0;
            default: m = '1;
         endcase
      end
      pick = $urandom_range(99);
      if (pick < 30) mv = $urandom_range(255);
      else if (pick < 60) mv = $urandom_range(1 << 17);
      else if (pick < 80) mv = $urandom;
      else if (pick < 90) mv = '0;
      else mv = ALL_ONES;
      send_measurement(idx, m, mv);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // lets every outstanding result come back and the unit go quiet
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fusion.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(int phase);
      case (phase)
         0, 5: begin
            write_csr(CSR_MIN_VARIANCE, $urandom_range(64, 1));
            write_csr(CSR_MAX_VARIANCE, $urandom_range(1 << 18, 1 << 14));
            write_csr(CSR_THRESHOLD_SQ, $urandom_range(1 << 21, 1 << 16));
            write_csr(CSR_RESET_DELTA, $urandom_range(1 << 16));
            write_csr(CSR_VARIANCE_BUMP, $urandom_range(1 << 12));
         end
         1: begin
            write_csr(CSR_MIN_VARIANCE, 32'd1);
            write_csr(CSR_MAX_VARIANCE, ALL_ONES);
            write_csr(CSR_THRESHOLD_SQ, 32'd1);
            write_csr(CSR_RESET_DELTA, '0);
            write_csr(CSR_VARIANCE_BUMP, ALL_ONES);
         end
         2: begin
            // crossed bounds: every variance lands on the upper bound
            write_csr(CSR_MIN_VARIANCE, ALL_ONES);
            write_csr(CSR_MAX_VARIANCE, 32'd1);
            write_csr(CSR_THRESHOLD_SQ, ALL_ONES);
            write_csr(CSR_RESET_DELTA, ALL_ONES);
            write_csr(CSR_VARIANCE_BUMP, '0);
         end
         3: begin
            write_csr(CSR_MIN_VARIANCE, MIN_VARIANCE_RST);
            write_csr(CSR_MAX_VARIANCE, MAX_VARIANCE_RST);
            write_csr(CSR_THRESHOLD_SQ, THRESHOLD_SQ_RST);
            write_csr(CSR_RESET_DELTA, RESET_DELTA_RST);
            write_csr(CSR_VARIANCE_BUMP, VARIANCE_BUMP_RST);
         end
         default: begin
            write_csr(CSR_MIN_VARIANCE, $urandom_range(1 << 10, 1));
            write_csr(CSR_MAX_VARIANCE, $urandom_range(ALL_ONES, 1));
            write_csr(CSR_THRESHOLD_SQ, $urandom_range(ALL_ONES, 1));
            write_csr(CSR_RESET_DELTA, $urandom);
            write_csr(CSR_VARIANCE_BUMP, $urandom);
         end
      endcase
      // writes past the register list must leave everything alone
      if (phase == 0 || phase == 4) begin
         for (int k = CSR_VARIANCE_BUMP + 1; k < (1 << CSR_IDX_W); k++) begin
            write_csr(CSR_IDX_W'(k), $urandom);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty cells at the field extremes
      send_measurement(0, '0, '0);
      send_measurement(IDX_W'(GRID_CELLS - 1), HEIGHT_MAX, ALL_ONES);
      send_measurement(1, HEIGHT_MIN, '0);
      // small step with a tiny cell variance: gain held at its floor
      send_measurement(0, 1000, 32'd65536);
      // large jumps up and down
      send_measurement(0, 655360, '0);
      send_measurement(0, -1310720, '0);
      send_measurement(IDX_W'(GRID_CELLS - 1), HEIGHT_MIN, '0);
      send_measurement(1, HEIGHT_MAX, '0);
      // gain held at its ceiling, then a step just under the jump threshold
      send_measurement(2, 12345, 32'd65536);
      send_measurement(2, 12346, '0);
      send_measurement(2, 18345, '0);
      // combined variance past 32 bits
      send_measurement(3, -5, 32'd1);
      send_measurement(3, -4, ALL_ONES);
      send_measurement(3, HEIGHT_MAX, ALL_ONES);
      // rounding of small negative corrections
      send_measurement(5, 100, 32'd200);
      send_measurement(5, 97, 32'd200);
      send_measurement(5, 96, 32'd1);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         configure(phase);
         for (int k = 0; k < HOT_CELLS; k++) hot_cells[k] = IDX_W'($urandom);
         hot_cells[0] = '0;
         hot_cells[1] = IDX_W'(GRID_CELLS - 1);
         no_idle = (phase == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
            send_random_measurement();
         end
      end
      no_idle = 1'b0;
      drain_results();

      if (fusion.pending() != 0) begin
         fusion.report($sformatf("%0d results never arrived", fusion.pending()));
      end
      if (fusion.errors == 0) begin
         $display("PASS cell_height_kalman_fusion_unit");
      end else begin
         $display("FAIL cell_height_kalman_fusion_unit");
      end
      $finish;
   end

endmodule
